// ===== hdl/vap_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex attribute packer package
// Beat types and shared constants for the vertex packing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package vap_pkg;
	localparam int CompW = 24;
	localparam int LenW  = 26;
	localparam int NumW  = 35;
	localparam int DivSteps = 9;

	typedef struct packed {
		logic signed [CompW-1:0] pos_x;
		logic signed [CompW-1:0] pos_y;
		logic signed [CompW-1:0] pos_z;
		logic signed [CompW-1:0] nor_x;
		logic signed [CompW-1:0] nor_y;
		logic signed [CompW-1:0] nor_z;
		logic signed [CompW-1:0] tan_x;
		logic signed [CompW-1:0] tan_y;
		logic signed [CompW-1:0] tan_z;
		logic signed [CompW-1:0] tex_u;
		logic signed [CompW-1:0] tex_v;
	} vap_in_t;

	typedef struct packed {
		logic [31:0] word_pos_xy;
		logic [31:0] word_pos_z;
		logic [31:0] word_nor_tan;
		logic [31:0] word_tex;
	} vap_out_t;

	// Per-vector divide job: magnitudes of numerators, signs, divisor
	typedef struct packed {
		logic            zero;
		logic            neg_a;
		logic            neg_b;
		logic [NumW-1:0] rem_a;
		logic [NumW-1:0] rem_b;
		logic [LenW-1:0] len;
		logic [DivSteps-1:0] q_a;
		logic [DivSteps-1:0] q_b;
	} vap_div_t;

	// Quantize a signed component: floor(v / 2^sh) + 32768, clamped to 16 bits
	function automatic logic [15:0] quant16(input logic signed [CompW-1:0] v,
		input logic [4:0] sh);
		logic signed [CompW-1:0] f;
		logic signed [CompW:0] s;
		begin
			f = v >>> sh;
			s = {f[CompW-1], f} + (CompW+1)'(32768);
			if (s < 0)
				quant16 = 16'h0000;
			else if (s > (CompW+1)'(65535))
				quant16 = 16'hFFFF;
			else
				quant16 = s[15:0];
		end
	endfunction

	// Byte from signed quotient: q + 128 clamped to 0..255
	function automatic logic [7:0] byte_code(input logic neg, input logic [DivSteps-1:0] qm,
		input logic rem_nz);
		logic signed [DivSteps+1:0] q;
		logic signed [DivSteps+1:0] s;
		begin
			q = neg ? -$signed({2'b00, qm}) - $signed({{(DivSteps+1){1'b0}}, rem_nz}) :
				$signed({2'b00, qm});
			s = q + (DivSteps+2)'(128);
			if (s < 0)
				byte_code = 8'd0;
			else if (s > (DivSteps+2)'(255))
				byte_code = 8'd255;
			else
				byte_code = s[7:0];
		end
	endfunction
endpackage
`default_nettype wire

// ===== hdl/vertex_attribute_packer_core.sv =====
// ----------------------------------------------------------------------------
// Vertex attribute packer core
// Packs one vertex into four 32-bit words through a pipelined datapath.
// ----------------------------------------------------------------------------
// Usage: present a vertex beat on in_data with in_valid; it is taken when
// in_ready is high. Results leave on out_data under out_valid/out_ready.
// Position and UV are quantized to 16 bits; normal and tangent go through
// octahedral encoding, whose divide by the L1 length runs as a restoring
// divider with one quotient bit per stage.
// A vertex passes the setup stage (loaded at the accepting edge), nine
// divide stages and the output stage. Throughput: one vertex per cycle
// while the output is not stalled by out_ready.
// Stages advance independently; when out_ready is low and the output
// stage is full, full stages hold and in_ready can drop, so nothing is lost.
// Bubbles are squeezed: a stage with no valid beat always takes new data.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_attribute_packer_core
	import vap_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire vap_in_t  in_data,
	input  wire logic     out_ready,
	output logic          out_valid,
	output vap_out_t      out_data
);
	localparam int NSt = DivSteps + 1;

	vap_div_t  jn_s [NSt];
	vap_div_t  jt_s [NSt];
	logic [63:0] q_s [NSt];
	logic      v_s  [NSt];
	logic      adv  [NSt];
	vap_div_t  jn_next [NSt];
	vap_div_t  jt_next [NSt];
	vap_div_t  prep_n, prep_t;
	logic      out_en;

	// Setup: lengths and numerators
	vap_oct_prep u_prep_n (.x(in_data.nor_x), .y(in_data.nor_y), .z(in_data.nor_z),
		.job(prep_n));
	vap_oct_prep u_prep_t (.x(in_data.tan_x), .y(in_data.tan_y), .z(in_data.tan_z),
		.job(prep_t));

	// Stall control: a stage may load when it is empty or the next one moves
	assign out_en = !out_valid || out_ready;
	always_comb begin
		adv[NSt-1] = !v_s[NSt-1] || out_en;
		for (int i = NSt-2; i >= 0; i--)
			adv[i] = !v_s[i] || adv[i+1];
	end
	assign in_ready = adv[0];

	// Divide steps, msb first
	for (genvar g = 1; g < NSt; g++) begin : g_div
		vap_div_step #(.Bit(DivSteps-g)) u_n (.ji(jn_s[g-1]), .jo(jn_next[g]));
		vap_div_step #(.Bit(DivSteps-g)) u_t (.ji(jt_s[g-1]), .jo(jt_next[g]));
	end
	assign jn_next[0] = prep_n;
	assign jt_next[0] = prep_t;

	// Pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSt; i++)
				v_s[i] <= 1'b0;
		end else begin
			v_s[0] <= adv[0] ? in_valid : v_s[0];
			for (int i = 1; i < NSt; i++)
				if (adv[i])
					v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			jn_s[0] <= jn_next[0];
			jt_s[0] <= jt_next[0];
			q_s[0]  <= {quant16(in_data.pos_x, 5'd1), quant16(in_data.pos_y, 5'd1),
				quant16(in_data.pos_z, 5'd1), quant16(in_data.tex_u, 5'd4)};
		end
		for (int i = 1; i < NSt; i++)
			if (adv[i]) begin
				jn_s[i] <= jn_next[i];
				jt_s[i] <= jt_next[i];
				q_s[i]  <= q_s[i-1];
			end
	end

	// Texture v rides separately to keep the payload narrow
	logic [15:0] tv_s [NSt];
	always_ff @(posedge clk) begin
		if (adv[0])
			tv_s[0] <= quant16(in_data.tex_v, 5'd4);
		for (int i = 1; i < NSt; i++)
			if (adv[i])
				tv_s[i] <= tv_s[i-1];
	end

	// Output stage: finish codes and pack
	logic [7:0] nb_a, nb_b, tb_a, tb_b;
	vap_div_t   jn_f, jt_f;
	always_comb begin
		jn_f = jn_s[NSt-1];
		jt_f = jt_s[NSt-1];
		nb_a = jn_f.zero ? 8'd128 : byte_code(jn_f.neg_a, jn_f.q_a, jn_f.rem_a != '0);
		nb_b = jn_f.zero ? 8'd128 : byte_code(jn_f.neg_b, jn_f.q_b, jn_f.rem_b != '0);
		tb_a = jt_f.zero ? 8'd128 : byte_code(jt_f.neg_a, jt_f.q_a, jt_f.rem_a != '0);
		tb_b = jt_f.zero ? 8'd128 : byte_code(jt_f.neg_b, jt_f.q_b, jt_f.rem_b != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_en)
			out_valid <= v_s[NSt-1];
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s[NSt-1]) begin
			out_data.word_pos_xy  <= {q_s[NSt-1][63:48], q_s[NSt-1][47:32]};
			out_data.word_pos_z   <= {q_s[NSt-1][31:16], 16'h0000};
			out_data.word_nor_tan <= {nb_a, nb_b, tb_a, tb_b};
			out_data.word_tex     <= {q_s[NSt-1][15:0], tv_s[NSt-1]};
		end
	end

	// Held output must not change while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");
	// Input accepted only when the first stage can load
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s[0])
		else $error("accepted beat lost in first stage");
	// Last stage full and output blocked freezes the pipe
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSt-1] && out_valid && !out_ready |-> !adv[NSt-1])
		else $error("last stage advanced into a stalled output");
endmodule
`default_nettype wire

// ===== hdl/vap_oct_prep.sv =====
// ----------------------------------------------------------------------------
// Octahedral setup
// Forms L1 length and the two numerator magnitudes with their signs.
// ----------------------------------------------------------------------------
`default_nettype none
module vap_oct_prep
	import vap_pkg::*;
(
	input  wire logic signed [CompW-1:0] x,
	input  wire logic signed [CompW-1:0] y,
	input  wire logic signed [CompW-1:0] z,
	output vap_div_t                     job
);
	logic [CompW:0] ax, ay, az;
	logic [LenW-1:0] len;
	logic [LenW-1:0] ma, mb;

	// Absolute values and length
	always_comb begin
		ax  = x[CompW-1] ? (CompW+1)'(-{x[CompW-1], x}) : (CompW+1)'({1'b0, x});
		ay  = y[CompW-1] ? (CompW+1)'(-{y[CompW-1], y}) : (CompW+1)'({1'b0, y});
		az  = z[CompW-1] ? (CompW+1)'(-{z[CompW-1], z}) : (CompW+1)'({1'b0, z});
		len = LenW'(ax) + LenW'(ay) + LenW'(az);
		if (!z[CompW-1] && z != '0) begin
			ma = LenW'(ax);
			mb = LenW'(ay);
		end else begin
			ma = len - LenW'(ay);
			mb = len - LenW'(ax);
		end
		job.zero  = (len == '0);
		job.neg_a = x[CompW-1];
		job.neg_b = y[CompW-1];
		job.rem_a = {ma, 7'd0, 2'b00} >> 2;
		job.rem_b = {mb, 7'd0, 2'b00} >> 2;
		job.len   = len;
		job.q_a   = '0;
		job.q_b   = '0;
	end
endmodule
`default_nettype wire

// ===== hdl/vap_div_step.sv =====
// ----------------------------------------------------------------------------
// Restoring divide step
// Produces one quotient bit of each numerator per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vap_div_step
	import vap_pkg::*;
#(
	parameter int Bit = 0
) (
	input  vap_div_t ji,
	output vap_div_t jo
);
	logic [NumW-1:0] d;

	// Compare against shifted divisor and subtract
	always_comb begin
		jo = ji;
		d  = NumW'(ji.len) << Bit;
		if (ji.rem_a >= d) begin
			jo.rem_a = ji.rem_a - d;
			jo.q_a[Bit] = 1'b1;
		end
		if (ji.rem_b >= d) begin
			jo.rem_b = ji.rem_b - d;
			jo.q_b[Bit] = 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Vertex attribute packer testbench
// Drives vertex beats through the packer with random gaps and output stalls,
// predicts the four packed words per vertex and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: predicts packed words per vertex, compares in arrival order
class vertex_scoreboard;
	vap_pkg::vap_out_t pending[$];
	int fails;
	int seen;

	function new();
		fails = 0;
		seen = 0;
	endfunction

	// floor(v / d) + 32768 clamped to 16 bits
	static function logic [15:0] quantize(logic signed [23:0] v, longint d);
		longint n, q;
		n = v;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		q = q + 32768;
		if (q < 0) return 16'h0000;
		if (q > 65535) return 16'hFFFF;
		return q[15:0];
	endfunction

	static function logic [7:0] to_byte(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		q = q + 128;
		if (q < 0) return 8'd0;
		if (q > 255) return 8'd255;
		return q[7:0];
	endfunction

	// Octahedral code: x byte high, y byte low
	static function logic [15:0] octa(logic signed [23:0] xi, logic signed [23:0] yi,
		logic signed [23:0] zi);
		longint x, y, z, ax, ay, l1, nx, ny;
		x = xi;
		y = yi;
		z = zi;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		l1 = ax + ay + (z < 0 ? -z : z);
		if (l1 == 0) return {8'd128, 8'd128};
		if (z > 0) begin
			nx = 128 * x;
			ny = 128 * y;
		end else begin
			nx = 128 * (l1 - ay);
			ny = 128 * (l1 - ax);
			if (x < 0) nx = -nx;
			if (y < 0) ny = -ny;
		end
		return {to_byte(nx, l1), to_byte(ny, l1)};
	endfunction

	function void note_vertex(vap_pkg::vap_in_t v);
		vap_pkg::vap_out_t w;
		w.word_pos_xy = {quantize(v.pos_x, 2), quantize(v.pos_y, 2)};
		w.word_pos_z = {quantize(v.pos_z, 2), 16'h0000};
		w.word_nor_tan = {octa(v.nor_x, v.nor_y, v.nor_z), octa(v.tan_x, v.tan_y, v.tan_z)};
		w.word_tex = {quantize(v.tex_u, 16), quantize(v.tex_v, 16)};
		pending.push_back(w);
	endfunction

	function void check_words(vap_pkg::vap_out_t got);
		vap_pkg::vap_out_t w;
		seen++;
		if (pending.size() == 0) begin
			$error("result with no vertex pending: %h", got);
			fails++;
			return;
		end
		w = pending.pop_front();
		if (got.word_pos_xy !== w.word_pos_xy) begin
			$error("word_pos_xy expected %h got %h", w.word_pos_xy, got.word_pos_xy);
			fails++;
		end
		if (got.word_pos_z !== w.word_pos_z) begin
			$error("word_pos_z expected %h got %h", w.word_pos_z, got.word_pos_z);
			fails++;
		end
		if (got.word_nor_tan !== w.word_nor_tan) begin
			$error("word_nor_tan expected %h got %h", w.word_nor_tan, got.word_nor_tan);
			fails++;
		end
		if (got.word_tex !== w.word_tex) begin
			$error("word_tex expected %h got %h", w.word_tex, got.word_tex);
			fails++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vap_pkg::*;

	localparam int RandVerts = 1130;
	localparam longint CycleLimit = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	vap_in_t in_data;
	logic out_ready;
	logic out_valid;
	vap_out_t out_data;

	vertex_scoreboard board;
	longint cycles;
	int sent;

	vertex_attribute_packer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		board = new();
	end

	// Count cycles; stop on timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Send one vertex beat after a random idle gap (none in bursts)
	task automatic send_vertex(input vap_in_t v, input bit burst);
		int n;
		n = burst ? 0 : $urandom_range(10);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (!in_ready);
		board.note_vertex(v);
		sent++;
	endtask

	// Component picker: edges, unit-ish, or full random
	function automatic logic [23:0] pick_comp();
		int k;
		k = $urandom_range(9);
		case (k)
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return 24'h010000;
			4: return 24'hFF0000;
			5, 6: return 24'($signed($urandom_range(131072)) - 65536);
			7: return 24'($signed($urandom_range(8)) - 4);
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic vap_in_t rand_vertex();
		vap_in_t v;
		v.pos_x = pick_comp();
		v.pos_y = pick_comp();
		v.pos_z = pick_comp();
		v.nor_x = pick_comp();
		v.nor_y = pick_comp();
		v.nor_z = pick_comp();
		v.tan_x = pick_comp();
		v.tan_y = pick_comp();
		v.tan_z = pick_comp();
		v.tex_u = ($urandom_range(3) == 0) ? 24'($urandom()) :
			24'($signed($urandom_range(1048576)) - 524288);
		v.tex_v = ($urandom_range(3) == 0) ? 24'($urandom()) :
			24'($signed($urandom_range(1048576)) - 524288);
		return v;
	endfunction

	function automatic vap_in_t fill_vertex(logic [23:0] p, logic [23:0] nx, logic [23:0] ny,
		logic [23:0] nz, logic [23:0] t);
		vap_in_t v;
		v.pos_x = p;
		v.pos_y = ~p;
		v.pos_z = p;
		v.nor_x = nx;
		v.nor_y = ny;
		v.nor_z = nz;
		v.tan_x = ny;
		v.tan_y = nz;
		v.tan_z = nx;
		v.tex_u = t;
		v.tex_v = ~t;
		return v;
	endfunction

	// Output: random wait per beat (none every third run of 64), then check
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = ((board.seen / 64) % 3 == 2) ? 0 : $urandom_range(10);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			board.check_words(out_data);
		end
	end

	initial begin
		int i;
		bit burst;
		in_valid = 1'b0;
		in_data = '0;
		sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: clamps, exact ends, zero vector, folding, sign of zero
		send_vertex(fill_vertex(24'h000000, 24'h000000, 24'h000000, 24'h000000,
			24'h000000), 0);
		send_vertex(fill_vertex(24'h800000, 24'h800000, 24'h800000, 24'h800000,
			24'h800000), 0);
		send_vertex(fill_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF), 0);
		send_vertex(fill_vertex(24'h010000, 24'h010000, 24'h000000, 24'h000000,
			24'h080000), 0);
		send_vertex(fill_vertex(24'hFF0000, 24'h000000, 24'h000000, 24'h010000,
			24'hF80000), 1);
		send_vertex(fill_vertex(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFF0000,
			24'hFFFFFF), 1);
		send_vertex(fill_vertex(24'h00FFFF, 24'hFF0000, 24'h000000, 24'h000000,
			24'h07FFFF), 1);
		send_vertex(fill_vertex(24'hFEFFFF, 24'h000000, 24'hFF0000, 24'h000000,
			24'hF7FFFF), 0);
		send_vertex(fill_vertex(24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'h00000F), 0);
		send_vertex(fill_vertex(24'hFFFFFE, 24'h000001, 24'h000001, 24'h000001,
			24'hFFFFF0), 0);
		send_vertex(fill_vertex(24'h555555, 24'h7FFFFF, 24'h800000, 24'h000000,
			24'hAAAAAA), 1);
		send_vertex(fill_vertex(24'hAAAAAA, 24'h000003, 24'hFFFFFD, 24'h000001,
			24'h555555), 0);
		send_vertex(fill_vertex(24'h008000, 24'h000000, 24'h000000, 24'h000001,
			24'h100000), 0);

		// Random vertices in stretches of 100, every third one (from the second) a burst
		for (i = 0; i < RandVerts; i++) begin
			burst = ((i / 100) % 3) == 1;
			send_vertex(rand_vertex(), burst);
		end
		in_valid <= 1'b0;

		// Drain, then let the pipe settle
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("covered %0d vertices: edge, zero, folded and random components", sent);
		$display("output stalls and input gaps mixed with back-to-back stretches");
		if (board.fails == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

`default_nettype wire
